FILE: rtl/core/hex_run_raster_line_decoder_assert.svh
// Assertion macros for the hex-run raster line decoder.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HEX_RUN_RASTER_LINE_DECODER_ASSERT_SVH
`define HEX_RUN_RASTER_LINE_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HRLD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hrld: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HRLD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hrld: next-cycle check failed");

`endif

FILE: rtl/core/hrld_pkg.sv
// Shared types and constants of the hex-run raster line decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hrld_pkg;

  // Line store geometry
  localparam int MAX_ROW_BYTES = 512;
  localparam int ROW_BYTES     = 8;
  localparam int BYTE_W        = 8;
  localparam int BYTE_AW       = $clog2(ROW_BYTES);
  localparam int ROWS          = MAX_ROW_BYTES / ROW_BYTES;
  localparam int ROW_AW        = $clog2(ROWS);
  localparam int PTR_W         = ROW_AW + BYTE_AW + 1;
  localparam int WORD_W        = ROW_BYTES * BYTE_W;

  // Field widths
  localparam int CHAR_W        = 8;
  localparam int CODE_W        = 7;
  localparam int CNT_W         = 7;
  localparam int ROW_CNT_W     = 16;
  localparam int RET_W         = 17;
  localparam int RASTER_W      = 10;
  localparam logic [RASTER_W-1:0] RASTER_RESET = RASTER_W'(300);

  // Configuration port
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;
  localparam logic REG_RASTER_SIZE = 1'b0;

  // Command queue
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  // Character codes
  localparam logic [CODE_W-1:0] CH_CLEAR   = 7'h24;  // '$'
  localparam logic [CODE_W-1:0] CH_REWIND  = 7'h3D;  // '='
  localparam logic [CODE_W-1:0] CH_DIG0    = 7'h30;  // '0'
  localparam logic [CODE_W-1:0] CH_DIG9    = 7'h39;  // '9'
  localparam logic [CODE_W-1:0] CH_HEXA    = 7'h41;  // 'A'
  localparam logic [CODE_W-1:0] CH_HEXF    = 7'h46;  // 'F'
  localparam logic [CODE_W-1:0] CH_REP_G   = 7'h47;  // 'G'
  localparam logic [CODE_W-1:0] CH_REP_N   = 7'h4E;  // 'N'
  localparam logic [CODE_W-1:0] CH_RUN_O   = 7'h4F;  // 'O'
  localparam logic [CODE_W-1:0] CH_RUN_T   = 7'h54;  // 'T'
  localparam logic [CODE_W-1:0] CH_XOR_ON  = 7'h58;  // 'X'
  localparam logic [CODE_W-1:0] CH_XOR_OFF = 7'h59;  // 'Y'
  localparam logic [CODE_W-1:0] CH_ROW_END = 7'h5A;  // 'Z'

  // Classified commands handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_FILL,
    OP_CLEAR,
    OP_REWIND,
    OP_XOR_ON,
    OP_XOR_OFF,
    OP_ROW_END
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [BYTE_W-1:0]  fill_byte;
    logic [CNT_W-1:0]   cnt;
  } cmd_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_RES,
    S_ZSTART,
    S_EMIT
  } back_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/hrld_front.sv
// Front end: accepts characters, pairs hex digits into bytes and classifies
// each character into a command for the queue. Depends on hrld_pkg.
`default_nettype none

module hrld_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_clr_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hrld_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                          full_i,
  output logic                          push_o,
  output hrld_pkg::cmd_t                cmd_o
);
  import hrld_pkg::*;

  logic                 pend_q, pend_d;
  logic [3:0]           hi_q, hi_d;
  logic [BYTE_W-1:0]    last_q, last_d;
  logic [CODE_W-1:0]    code;
  logic [CODE_W-1:0]    dig_val;
  logic [CODE_W-1:0]    rep_val;
  logic [CODE_W-1:0]    run_val;
  logic                 is_hex;
  logic [3:0]           nib;

  assign code       = char_code_i[CODE_W-1:0];
  assign push_o     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  // Digit value, repeat count and run length offsets
  always_comb begin
    dig_val = code - CH_DIG0;
    rep_val = code - (CH_REP_G - CODE_W'(1));
    run_val = code - (CH_RUN_O - CODE_W'(1));
    is_hex  = 1'b0;
    nib     = '0;
    if (code >= CH_DIG0 && code <= CH_DIG9) begin
      is_hex = 1'b1;
      nib    = dig_val[3:0];
    end else if (code >= CH_HEXA && code <= CH_HEXF) begin
      is_hex = 1'b1;
      nib    = 4'(code - (CH_HEXA - CODE_W'(10)));
    end
  end

  // Classify and update digit pairing state
  always_comb begin
    cmd_o.op        = OP_NOP;
    cmd_o.fill_byte = last_q;
    cmd_o.cnt       = '0;
    pend_d          = pend_q;
    hi_d            = hi_q;
    last_d          = last_q;
    priority if (code == CH_CLEAR || code == CH_REWIND || code == CH_ROW_END) begin
      if (code == CH_CLEAR) begin
        cmd_o.op = OP_CLEAR;
      end else if (code == CH_REWIND) begin
        cmd_o.op = OP_REWIND;
      end else begin
        cmd_o.op = OP_ROW_END;
      end
      pend_d = 1'b0;
      hi_d   = '0;
      last_d = '0;
    end else if (is_hex) begin
      if (!pend_q) begin
        pend_d = 1'b1;
        hi_d   = nib;
      end else begin
        cmd_o.op        = OP_FILL;
        cmd_o.fill_byte = {hi_q, nib};
        cmd_o.cnt       = CNT_W'(1);
        pend_d          = 1'b0;
        hi_d            = '0;
        last_d          = {hi_q, nib};
      end
    end else if (code >= CH_REP_G && code <= CH_REP_N) begin
      cmd_o.op  = OP_FILL;
      cmd_o.cnt = rep_val;
    end else if (code >= CH_RUN_O && code <= CH_RUN_T) begin
      cmd_o.op  = OP_FILL;
      cmd_o.cnt = {run_val[2:0], 4'b0000};
    end else if (code == CH_XOR_ON) begin
      cmd_o.op = OP_XOR_ON;
    end else if (code == CH_XOR_OFF) begin
      cmd_o.op = OP_XOR_OFF;
    end else begin
      cmd_o.op = OP_NOP;
    end
  end

  // Pairing state: cleared on config write, advanced on each accepted push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      hi_q   <= '0;
      last_q <= '0;
    end else if (cfg_clr_i) begin
      pend_q <= 1'b0;
      hi_q   <= '0;
      last_q <= '0;
    end else if (push_o) begin
      pend_q <= pend_d;
      hi_q   <= hi_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hrld_queue.sv
// Short command queue between front and back end.
// Depends on hrld_pkg for the command type and depth.
`default_nettype none

module hrld_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrld_pkg::cmd_t  cmd_i,
  output logic            full_o,
  output logic            valid_o,
  output hrld_pkg::cmd_t  cmd_o,
  input  logic            pop_i
);
  import hrld_pkg::*;

  cmd_t                 slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_q, rd_q;
  logic [QUEUE_AW:0]    cnt_q;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  // Store entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hrld_back.sv
// Back end: executes commands against the 64-bit-row line store, emits rows.
// Depends on hrld_pkg and the assertion macro header.
`default_nettype none
`include "hex_run_raster_line_decoder_assert.svh"

module hrld_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_clr_i,
  input  logic [hrld_pkg::PTR_W-1:0]       size_i,
  input  logic                             cmd_valid_i,
  input  hrld_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hrld_pkg::WORD_W-1:0]      row_word_o,
  output logic                             row_word_valid_o,
  output logic [hrld_pkg::RET_W-1:0]       ret_o,
  output logic                             last_o
);
  import hrld_pkg::*;

  back_state_e            state_q, state_d;
  logic [PTR_W-1:0]       wp_q, wp_d, end_q, end_d;
  logic [BYTE_W-1:0]      fill_q, fill_d;
  logic                   zfill_q, zfill_d;
  logic                   xor_q, xor_d;
  logic [ROW_CNT_W-1:0]   rc_q, rc_d;
  logic [ROWS-1:0]        vld_q, vld_d;
  logic [ROW_AW-1:0]      w_q, w_d;

  logic [WORD_W-1:0]      mem [ROWS];
  logic [WORD_W-1:0]      rdata_q;
  logic                   rvld_q;
  logic [ROW_AW-1:0]      raddr, wrow;
  logic                   mem_we;
  logic [WORD_W-1:0]      row_old, merged, emit_word;

  logic [PTR_W:0]         fill_sum, size_sum;
  logic [PTR_W-1:0]       fill_end, row_next, wr_next;
  logic [ROW_AW:0]        words;
  logic                   go_fill, go_zfill, go_zstart, wr_done, emit_last, out_free;

  logic                   res_load, res_wvld, res_last;
  logic [WORD_W-1:0]      res_word;
  logic [RET_W-1:0]       res_ret;

  logic                   out_valid_q;
  logic [WORD_W-1:0]      out_word_q;
  logic                   out_wvld_q, out_last_q;
  logic [RET_W-1:0]       out_ret_q;

  // Decode helpers
  assign out_free  = !out_valid_q || !out_stall_i;
  assign wrow      = wp_q[ROW_AW+BYTE_AW-1:BYTE_AW];
  assign fill_sum  = {1'b0, wp_q} + (PTR_W+1)'(cmd_i.cnt);
  assign fill_end  = (fill_sum > {1'b0, size_i}) ? size_i : fill_sum[PTR_W-1:0];
  assign go_fill   = cmd_valid_i && (cmd_i.op == OP_FILL) && (wp_q < fill_end);
  assign go_zfill  = cmd_valid_i && (cmd_i.op == OP_ROW_END) && !xor_q && (wp_q < size_i);
  assign go_zstart = cmd_valid_i && (cmd_i.op == OP_ROW_END) && !go_zfill;
  assign row_next  = {(ROW_AW+1)'(wrow) + (ROW_AW+1)'(1), BYTE_AW'(0)};
  assign wr_next   = (row_next < end_q) ? row_next : end_q;
  assign wr_done   = (wr_next == end_q);
  assign size_sum  = {1'b0, size_i} + (PTR_W+1)'(ROW_BYTES-1);
  assign words     = size_sum[ROW_AW+BYTE_AW:BYTE_AW];
  assign emit_last = ({1'b0, w_q} == words - (ROW_AW+1)'(1));
  assign row_old   = rvld_q ? rdata_q : '0;

  // Merge the run into the current row, mask emitted bytes past the size
  always_comb begin
    for (int j = 0; j < ROW_BYTES; j++) begin
      if (({1'b0, wrow, BYTE_AW'(j)} >= wp_q) && ({1'b0, wrow, BYTE_AW'(j)} < end_q)) begin
        merged[j*BYTE_W +: BYTE_W] = fill_q ^
            ((xor_q && !zfill_q) ? row_old[j*BYTE_W +: BYTE_W] : '0);
      end else begin
        merged[j*BYTE_W +: BYTE_W] = row_old[j*BYTE_W +: BYTE_W];
      end
      emit_word[j*BYTE_W +: BYTE_W] = ({1'b0, w_q, BYTE_AW'(j)} < size_i) ?
          row_old[j*BYTE_W +: BYTE_W] : '0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_fill || go_zfill) begin
          state_d = S_WR;
        end else if (go_zstart) begin
          state_d = S_ZSTART;
        end
      end
      S_WR: begin
        if (wr_done) begin
          if (zfill_q) begin
            state_d = S_ZSTART;
          end else begin
            state_d = out_free ? S_IDLE : S_RES;
          end
        end
      end
      S_RES: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_ZSTART: begin
        state_d = (words == '0) ? S_RES : S_EMIT;
      end
      S_EMIT: begin
        if (out_free && emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and result control
  always_comb begin
    wp_d      = wp_q;
    end_d     = end_q;
    fill_d    = fill_q;
    zfill_d   = zfill_q;
    xor_d     = xor_q;
    rc_d      = rc_q;
    vld_d     = vld_q;
    w_d       = w_q;
    raddr     = wrow;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    res_load  = 1'b0;
    res_word  = '0;
    res_wvld  = 1'b0;
    res_last  = 1'b1;
    res_ret   = {1'b0, rc_q};
    unique case (state_q)
      S_IDLE: begin
        if (go_fill) begin
          end_d   = fill_end;
          fill_d  = cmd_i.fill_byte;
          zfill_d = 1'b0;
        end else if (go_zfill) begin
          end_d   = size_i;
          fill_d  = '0;
          zfill_d = 1'b1;
        end else if (cmd_valid_i && !go_zstart && out_free) begin
          res_load  = 1'b1;
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_CLEAR: begin
              res_ret = '0;
              vld_d   = '0;
              wp_d    = '0;
              rc_d    = '0;
              xor_d   = 1'b0;
            end
            OP_REWIND: begin
              res_ret = '1;
              wp_d    = '0;
              rc_d    = '0;
            end
            OP_XOR_ON:  xor_d = 1'b1;
            OP_XOR_OFF: xor_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_WR: begin
        mem_we      = 1'b1;
        vld_d[wrow] = 1'b1;
        wp_d        = wr_next;
        raddr       = wr_next[ROW_AW+BYTE_AW-1:BYTE_AW];
        if (wr_done && !zfill_q && out_free) begin
          res_load  = 1'b1;
          cmd_pop_o = 1'b1;
        end
      end
      S_RES: begin
        if (out_free) begin
          res_load  = 1'b1;
          cmd_pop_o = 1'b1;
        end
      end
      S_ZSTART: begin
        rc_d  = rc_q + 1'b1;
        wp_d  = '0;
        w_d   = '0;
        raddr = '0;
      end
      S_EMIT: begin
        raddr = w_q;
        if (out_free) begin
          res_load = 1'b1;
          res_word = emit_word;
          res_wvld = 1'b1;
          res_last = emit_last;
          if (emit_last) begin
            cmd_pop_o = 1'b1;
          end else begin
            w_d   = w_q + 1'b1;
            raddr = w_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
    // Drop all row state on a configuration write
    if (cfg_clr_i) begin
      vld_d = '0;
      wp_d  = '0;
      rc_d  = '0;
      xor_d = 1'b0;
    end
  end

  // Line store: one row write and one row read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wrow] <= merged;
    end
    rdata_q <= mem[raddr];
    rvld_q  <= vld_q[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      end_q       <= '0;
      zfill_q     <= 1'b0;
      xor_q       <= 1'b0;
      rc_q        <= '0;
      vld_q       <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      end_q       <= end_d;
      zfill_q     <= zfill_d;
      xor_q       <= xor_d;
      rc_q        <= rc_d;
      vld_q       <= vld_d;
      w_q         <= w_d;
      out_valid_q <= res_load || (out_valid_q && out_stall_i);
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    if (res_load) begin
      out_word_q <= res_word;
      out_wvld_q <= res_wvld;
      out_last_q <= res_last;
      out_ret_q  <= res_ret;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_word_o       = out_word_q;
  assign row_word_valid_o = out_wvld_q;
  assign ret_o            = out_ret_q;
  assign last_o           = out_last_q;

  `HRLD_ASSERT_IMP(a_wp_in_row, 1'b1, wp_q <= size_i)
  `HRLD_ASSERT_IMP(a_wr_in_range, state_q == S_WR, (wp_q < end_q) && (end_q <= size_i))
  `HRLD_ASSERT_IMP(a_pop_on_last, cmd_pop_o, res_load && res_last)
  `HRLD_ASSERT_NXT(a_row_restart, state_q == S_ZSTART,
                   (wp_q == '0) && (state_q == S_RES || state_q == S_EMIT))

endmodule

`default_nettype wire

FILE: rtl/core/hex_run_raster_line_decoder.sv
// Top level of the hex-run raster line decoder: configuration port, front end,
// command queue and back end. Depends on hrld_pkg, hrld_front, hrld_queue, hrld_back.
//
// One 7-bit character per transaction (bit 7 ignored) builds a raster row in a
// 512-byte line store kept as 64 rows of 8 bytes with a valid bit per row, so
// reset and clear take effect at once with no sweep. The front end pairs hex
// digits and classifies characters into a two-entry queue, so input keeps
// flowing while the back end works. In the back end, commands and the first digit
// of a pair touch no store row, a completed hex byte does a read-modify-write of
// one store row, a repeat run writes each 8-byte store row it touches, and Z
// zero-fills the rest of the row outside XOR mode, counts the row and emits one
// 8-byte word per store row (ceil(size/8) words, or a single invalid result when
// the size is zero). A result is held in an output register and blocks the back
// end only while it is stalled. raster_size at byte address 0 sets the row
// length (clipped to 512) and clears the row state.
`default_nettype none

module hex_run_raster_line_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hrld_pkg::CHAR_W-1:0]         char_code_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [hrld_pkg::WORD_W-1:0]         row_word_o,
  output logic                                row_word_valid_o,
  output logic signed [hrld_pkg::RET_W-1:0]   return_value_o,
  output logic                                last_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hrld_pkg::APB_AW-1:0]         paddr,
  input  logic [hrld_pkg::APB_DW-1:0]         pwdata,
  output logic [hrld_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import hrld_pkg::*;

  logic [RASTER_W-1:0]  raster_q;
  logic [PTR_W-1:0]     size;
  logic                 cfg_wr;
  logic                 push, q_full, q_valid, q_pop;
  cmd_t                 push_cmd, head_cmd;
  logic [RET_W-1:0]     ret;

  // Register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[BYTE_AW-1] == REG_RASTER_SIZE);
  assign prdata = (paddr[BYTE_AW-1] == REG_RASTER_SIZE) ?
                  {(APB_DW-RASTER_W)'(0), raster_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_q <= RASTER_RESET;
    end else if (cfg_wr) begin
      raster_q <= pwdata[RASTER_W-1:0];
    end
  end

  // Clip row length to the store depth
  assign size = (raster_q > RASTER_W'(MAX_ROW_BYTES)) ? PTR_W'(MAX_ROW_BYTES)
                                                       : PTR_W'(raster_q);

  hrld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clr_i   (cfg_wr),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .full_i      (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  hrld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (q_pop)
  );

  hrld_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_clr_i        (cfg_wr),
    .size_i           (size),
    .cmd_valid_i      (q_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .row_word_o       (row_word_o),
    .row_word_valid_o (row_word_valid_o),
    .ret_o            (ret),
    .last_o           (last_o)
  );

  assign return_value_o = signed'(ret);

endmodule

`default_nettype wire

FILE: bench/tb_hex_run_raster_line_decoder.sv
`timescale 1ns / 100ps
// Testbench for hex_run_raster_line_decoder: streams characters and row-size writes,
// predicts every result transaction and compares it field by field.
// Depends on hrld_pkg and the block's RTL only.

module tb_hex_run_raster_line_decoder;
  import hrld_pkg::*;

  localparam logic [APB_AW-1:0] RASTER_SIZE_ADDR = APB_AW'(4 * REG_RASTER_SIZE);
  localparam int IDLE_PCT      = 26;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 250;

  typedef struct {
    logic [WORD_W-1:0]       word;
    logic                    word_ok;
    logic signed [RET_W-1:0] ret;
    logic                    last_flag;
  } row_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CHAR_W-1:0]         char_code_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [WORD_W-1:0]         row_word_o;
  logic                      row_word_valid_o;
  logic signed [RET_W-1:0]   return_value_o;
  logic                      last_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  // Predicted line decoder state
  logic [BYTE_W-1:0]         line_mem [MAX_ROW_BYTES];
  int unsigned               wr_ptr;
  logic                      nib_pending;
  logic [3:0]                hi_nib;
  logic [BYTE_W-1:0]         prev_byte;
  logic                      xor_on;
  logic [ROW_CNT_W-1:0]      rows_done;
  logic [RASTER_W-1:0]       size_reg;

  row_result_t               expected_words [$];
  int                        mismatches = 0;
  logic                      idle_en;
  int                        hold_left = 0;

  hex_run_raster_line_decoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .row_word_o       (row_word_o),
    .row_word_valid_o (row_word_valid_o),
    .return_value_o   (return_value_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Row predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned row_bytes();
    return (size_reg < MAX_ROW_BYTES) ? int'(size_reg) : MAX_ROW_BYTES;
  endfunction

  function automatic void push_result(logic [WORD_W-1:0] w, logic ok,
                                      logic signed [RET_W-1:0] r, logic l);
    row_result_t e;
    e.word      = w;
    e.word_ok   = ok;
    e.ret       = r;
    e.last_flag = l;
    expected_words.push_back(e);
  endfunction

  // Drop bytes past the row end; merge with the old byte in XOR mode
  function automatic void store_byte(logic [BYTE_W-1:0] b);
    if (wr_ptr < row_bytes()) begin
      line_mem[wr_ptr] = xor_on ? (b ^ line_mem[wr_ptr]) : b;
      wr_ptr++;
    end
  endfunction

  function automatic void restart_row();
    rows_done   = '0;
    wr_ptr      = 0;
    nib_pending = 1'b0;
    hi_nib      = '0;
    prev_byte   = '0;
  endfunction

  function automatic void clear_line();
    restart_row();
    xor_on = 1'b0;
    for (int i = 0; i < row_bytes(); i++) line_mem[i] = '0;
  endfunction

  function automatic void take_nibble(logic [3:0] v);
    logic [BYTE_W-1:0] b;
    if (!nib_pending) begin
      hi_nib      = v;
      nib_pending = 1'b1;
    end else begin
      b = {hi_nib, v};
      store_byte(b);
      prev_byte   = b;
      nib_pending = 1'b0;
      hi_nib      = '0;
    end
  endfunction

  function automatic void repeat_last(int unsigned n);
    int unsigned k;
    k = row_bytes() - wr_ptr;
    if (n < k) k = n;
    repeat (k) store_byte(prev_byte);
  endfunction

  // Zero-fill the tail (kept in XOR mode), count the row, emit 8-byte words
  function automatic void finish_row();
    int unsigned             bytes, words;
    logic [WORD_W-1:0]       w;
    logic signed [RET_W-1:0] r;
    bytes = row_bytes();
    if (!xor_on)
      for (int unsigned i = wr_ptr; i < bytes; i++) line_mem[i] = '0;
    rows_done++;
    wr_ptr      = 0;
    nib_pending = 1'b0;
    hi_nib      = '0;
    prev_byte   = '0;
    r     = {1'b0, rows_done};
    words = (bytes + 7) / 8;
    if (words == 0) push_result('0, 1'b0, r, 1'b1);
    for (int unsigned n = 0; n < words; n++) begin
      w = '0;
      for (int unsigned i = 0; i < 8; i++)
        if (n * 8 + i < bytes) w[8*i +: 8] = line_mem[n*8 + i];
      push_result(w, 1'b1, r, n + 1 == words);
    end
  endfunction

  function automatic void decode_char(logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0]       code;
    logic signed [RET_W-1:0] r;
    code = ch[CODE_W-1:0];
    r    = {1'b0, rows_done};
    if (code == CH_ROW_END) begin
      finish_row();
      return;
    end
    if (code == CH_CLEAR) begin
      clear_line();
      r = '0;
    end else if (code == CH_REWIND) begin
      restart_row();
      r = '1;
    end else if (code >= CH_DIG0 && code <= CH_DIG9) begin
      take_nibble(4'(code - CH_DIG0));
    end else if (code >= CH_HEXA && code <= CH_HEXF) begin
      take_nibble(4'(code - CH_HEXA + 7'd10));
    end else if (code >= CH_REP_G && code <= CH_REP_N) begin
      repeat_last(int'(code - CH_REP_G) + 1);
    end else if (code >= CH_RUN_O && code <= CH_RUN_T) begin
      repeat_last((int'(code - CH_RUN_O) + 1) * 16);
    end else if (code == CH_XOR_ON) begin
      xor_on = 1'b1;
    end else if (code == CH_XOR_OFF) begin
      xor_on = 1'b0;
    end
    push_result('0, 1'b0, r, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off when requested
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each accepted result transaction with the oldest prediction
  always @(posedge clk_i) begin
    row_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result with nothing expected: row_word %h return_value %0d",
                 $time, row_word_o, return_value_o);
        mismatches++;
      end else begin
        e = expected_words.pop_front();
        if (row_word_o !== e.word) begin
          $display("%0t: row_word expected %h actual %h", $time, e.word, row_word_o);
          mismatches++;
        end
        if (row_word_valid_o !== e.word_ok) begin
          $display("%0t: row_word_valid expected %b actual %b",
                   $time, e.word_ok, row_word_valid_o);
          mismatches++;
        end
        if (return_value_o !== e.ret) begin
          $display("%0t: return_value expected %0d actual %0d",
                   $time, e.ret, return_value_o);
          mismatches++;
        end
        if (last_o !== e.last_flag) begin
          $display("%0t: last expected %b actual %b", $time, e.last_flag, last_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one character, hold it until accepted, then predict its results
  task automatic send_char(logic [CHAR_W-1:0] ch);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    decode_char(ch);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]));
  endtask

  // Drop valid and wait for every predicted result to come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the row size while idle, then read it back
  task automatic write_size(logic [RASTER_W-1:0] n);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RASTER_SIZE_ADDR;
    pwdata  <= APB_DW'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_reg = n;
    clear_line();
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(n)) begin
      $display("%0t: raster_size read expected %h actual %h", $time, APB_DW'(n), prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] hex_code(int unsigned v);
    return (v < 10) ? CH_DIG0 + CODE_W'(v) : CH_HEXA + CODE_W'(v - 10);
  endfunction

  // Mostly row content, with some noise; bit 7 random throughout
  function automatic logic [CHAR_W-1:0] rand_row_char();
    int unsigned       pick;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(99);
    if (pick < 60)      code = hex_code($urandom_range(15));
    else if (pick < 78) code = CH_REP_G + CODE_W'($urandom_range(7));
    else if (pick < 84) code = CH_RUN_O + CODE_W'($urandom_range(5));
    else if (pick < 90) code = $urandom_range(1) ? CH_XOR_ON : CH_XOR_OFF;
    else                code = CODE_W'($urandom_range(127));
    return {1'($urandom_range(1)), code};
  endfunction

  // Rows of random content, mostly closed by a row end
  task automatic run_random_rows(int items);
    int          sent;
    int          len;
    int unsigned pick;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(10);
      repeat (len) begin
        send_char(rand_row_char());
        sent++;
      end
      pick = $urandom_range(99);
      if (pick < 85)      send_char({1'($urandom_range(1)), CH_ROW_END});
      else if (pick < 92) send_char({1'($urandom_range(1)), CH_CLEAR});
      else                send_char({1'($urandom_range(1)), CH_REWIND});
      sent++;
    end
  endtask

  task automatic random_phase(logic [RASTER_W-1:0] n, int items);
    write_size(n);
    run_random_rows(items);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_basic_commands();
    // Clear, byte extremes, both repeat families, XOR on and off, row end
    send_text("$00FFGNOTXA5YZ");
    // Ignored characters only report the row count
    send_text(":@UVW[a/");
    // Row end with bit 7 set, then rewind
    send_char({1'b1, CH_ROW_END});
    send_char({1'b0, CH_REWIND});
  endtask

  task automatic test_row_limits();
    // One-byte row: later bytes and repeats are dropped
    write_size(10'd1);
    send_text("12345GZ");
    // Zero size: row end gives one empty result
    write_size('0);
    send_text("AAGZ");
    // Full line store
    write_size(10'd512);
    send_text("7EHZ");
  endtask

  task automatic test_random_sizes();
    random_phase(10'd8, 24);
    random_phase(10'd13, 24);
    random_phase(10'd2, 24);
    random_phase(10'd24, 24);
    random_phase(10'd300, 16);
    random_phase(10'd9, 24);
    random_phase(10'd1023, 10);
    random_phase(10'd64, 24);
  endtask

  task automatic test_stall_pressure();
    write_size(10'd16);
    // Hold the receiver off so the block fills and stalls its input
    hold_left <= HOLD_CYCLES;
    run_random_rows(40);
    // Pause the sender until all results are back, then resume
    drain_results();
    run_random_rows(20);
  endtask

  task automatic test_back_to_back();
    write_size(10'd40);
    idle_en <= 1'b0;
    run_random_rows(50);
    drain_results();
    idle_en <= 1'b1;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    char_code_i <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    idle_en     <= 1'b1;
    size_reg = RASTER_RESET;
    for (int i = 0; i < MAX_ROW_BYTES; i++) line_mem[i] = '0;
    restart_row();
    xor_on = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_row_limits();
    test_random_sizes();
    test_stall_pressure();
    test_back_to_back();

    drain_results();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
